[rtl/fjsl_pkg.sv]
`timescale 1ns / 1ps

package fjsl_pkg;

    localparam int JOINTS_DEFAULT = 18;

    localparam int ANGLE_W = 24;
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int REG_W   = 23;
    localparam int JOINT_W = 5;
    localparam int KIND_W  = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [REG_W-1:0] STEP_LIMIT_RESET     = 23'd1464;
    localparam logic [REG_W-1:0] DONE_THRESHOLD_RESET = 23'd91506;

    localparam logic [KIND_W-1:0] KIND_TARGET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PRESET = 2'd2;

    localparam logic REG_STEP_LIMIT     = 1'b0;
    localparam logic REG_DONE_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [JOINT_W-1:0]        joint;
        logic signed [ANGLE_W-1:0] angle;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic [JOINT_W-1:0]        out_joint;
        logic signed [ANGLE_W-1:0] command;
        logic                      fading;
    } result_t;

    typedef struct packed {
        logic [REG_W-1:0] step_limit;
        logic [REG_W-1:0] done_threshold;
    } cfg_t;

    typedef struct packed {
        logic                      emit;
        logic                      write_cmd;
        logic signed [ANGLE_W-1:0] cmd;
        logic                      fade;
        logic [DIFF_W-1:0]         largest;
    } upd_t;

endpackage

[rtl/joint_fade_slew_limiter.sv]
`timescale 1ns / 1ps

// Slew-rate limited fade-in of joint commands.
// Item channel (item_valid / item_stall / item): one beat per joint target,
// start-fading marker or preset of a joint's commanded angle.
// Result channel (result_valid / result_stall / result): one beat for each
// accepted joint target with an in-range joint index; other beats give none.
// Throughput: one item per cycle while item_stall is low. Each item is captured
// in an input register and resolved from there by a single pass through the
// per-joint angle table, clamp and compare. That pass loads a target's result
// into the result register, from which the result beat is then offered.
// When result_stall holds a waiting result, one further item is still taken
// into the input register; item_stall rises only when that item would need
// the occupied result register. Start and preset items never wait on it.
// The APB port holds step_limit (0x0) and done_threshold (0x4); pready is
// always high. Write them only while the block is idle.
// Reset clears every commanded angle to zero, sets fading, clears the
// running maximum and empties both registers; items are taken right after.
module joint_fade_slew_limiter
#(
    parameter int JOINTS = fjsl_pkg::JOINTS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  fjsl_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output fjsl_pkg::result_t                 result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fjsl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fjsl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fjsl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import fjsl_pkg::*;

    localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    cfg_t                       cfg;
    upd_t                       upd;

    item_t                      item_reg;
    logic                       item_valid_reg;
    result_t                    result_reg;
    logic                       result_valid_reg;
    logic signed [ANGLE_W-1:0]  cmd_reg [JOINTS];
    logic                       fade_reg;
    logic [DIFF_W-1:0]          largest_reg;

    logic                       in_range;
    logic [JIDX_W-1:0]          idx;
    logic signed [ANGLE_W-1:0]  cur_cmd;
    logic                       out_free;
    logic                       proc_fire;
    logic                       result_valid_next;

    fjsl_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_range = (32'(item_reg.joint) < 32'(JOINTS));
    assign idx      = JIDX_W'(item_reg.joint);
    assign cur_cmd  = in_range ? cmd_reg[idx] : '0;

    fjsl_update u_update
    (
        .item     (item_reg),
        .in_range (in_range),
        .cur_cmd  (cur_cmd),
        .fade     (fade_reg),
        .largest  (largest_reg),
        .cfg      (cfg),
        .upd      (upd)
    );

    assign out_free   = !result_valid_reg || !result_stall;
    assign proc_fire  = item_valid_reg && (out_free || !upd.emit);
    assign item_stall = item_valid_reg && !proc_fire;

    always_comb
    begin
        if (proc_fire && upd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            fade_reg         <= 1'b1;
            largest_reg      <= '0;
            for (int i = 0; i < JOINTS; i++)
            begin
                cmd_reg[i] <= '0;
            end
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            result_valid_reg <= result_valid_next;
            if (proc_fire)
            begin
                fade_reg    <= upd.fade;
                largest_reg <= upd.largest;
                if (upd.write_cmd)
                begin
                    cmd_reg[idx] <= upd.cmd;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
        if (proc_fire && upd.emit)
        begin
            result_reg.out_joint <= item_reg.joint;
            result_reg.command   <= upd.cmd;
            result_reg.fading    <= upd.fade;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/fjsl_apb_regs.sv]
`timescale 1ns / 1ps

module fjsl_apb_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fjsl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fjsl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fjsl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output fjsl_pkg::cfg_t                    cfg
);
    import fjsl_pkg::*;

    logic [REG_W-1:0] step_limit_reg;
    logic [REG_W-1:0] done_threshold_reg;
    logic             wr_en;
    logic             sel;

    assign sel    = paddr[2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg     <= STEP_LIMIT_RESET;
            done_threshold_reg <= DONE_THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            if (sel == REG_STEP_LIMIT)
            begin
                step_limit_reg <= pwdata[REG_W-1:0];
            end
            else
            begin
                done_threshold_reg <= pwdata[REG_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (sel == REG_DONE_THRESHOLD)
        begin
            prdata = APB_DATA_W'(done_threshold_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(step_limit_reg);
        end
    end

    assign cfg.step_limit     = step_limit_reg;
    assign cfg.done_threshold = done_threshold_reg;

endmodule

[rtl/fjsl_update.sv]
`timescale 1ns / 1ps

module fjsl_update
(
    input  fjsl_pkg::item_t                          item,
    input  logic                                     in_range,
    input  logic signed [fjsl_pkg::ANGLE_W-1:0]      cur_cmd,
    input  logic                                     fade,
    input  logic [fjsl_pkg::DIFF_W-1:0]              largest,
    input  fjsl_pkg::cfg_t                           cfg,
    output fjsl_pkg::upd_t                           upd
);
    import fjsl_pkg::*;

    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          mag;
    logic signed [DIFF_W:0]     diff_x;
    logic signed [DIFF_W:0]     lim_pos;
    logic signed [DIFF_W:0]     lim_neg;
    logic signed [DIFF_W:0]     step;
    logic signed [DIFF_W:0]     sum;
    logic [DIFF_W-1:0]          max_new;
    logic signed [ANGLE_W-1:0]  cmd_new;
    logic                       fade_new;

    always_comb
    begin
        diff    = DIFF_W'(item.angle) - DIFF_W'(cur_cmd);
        mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        diff_x  = (DIFF_W+1)'(diff);
        lim_pos = signed'({3'b000, cfg.step_limit});
        lim_neg = -lim_pos;
        priority if (diff_x > lim_pos)
        begin
            step = lim_pos;
        end
        else if (diff_x < lim_neg)
        begin
            step = lim_neg;
        end
        else
        begin
            step = diff_x;
        end
        sum = (DIFF_W+1)'(cur_cmd) + step;

        max_new  = largest;
        fade_new = fade;
        if (fade)
        begin
            cmd_new = sum[ANGLE_W-1:0];
            if (mag > largest)
            begin
                max_new = mag;
            end
        end
        else
        begin
            cmd_new = item.angle;
        end
        if (item.last)
        begin
            if (fade && (max_new < DIFF_W'(cfg.done_threshold)))
            begin
                fade_new = 1'b0;
            end
            max_new = '0;
        end

        upd.emit      = 1'b0;
        upd.write_cmd = 1'b0;
        upd.cmd       = cmd_new;
        upd.fade      = fade;
        upd.largest   = largest;
        unique case (item.kind)
            KIND_START:
            begin
                upd.fade    = 1'b1;
                upd.largest = '0;
            end
            KIND_PRESET:
            begin
                if (in_range)
                begin
                    upd.write_cmd = 1'b1;
                    upd.cmd       = item.angle;
                end
            end
            KIND_TARGET:
            begin
                if (in_range)
                begin
                    upd.emit      = 1'b1;
                    upd.write_cmd = 1'b1;
                    upd.fade      = fade_new;
                    upd.largest   = max_new;
                end
            end
            default:
            begin
                upd.emit = 1'b0;
            end
        endcase
    end

endmodule
